// ----- hdl/assert_macros.svh -----
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("lbl");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error("lbl");
`endif

// ----- hdl/imht_pkg.sv -----
// ----------------------------------------------------------------------------
// imht_pkg
// Types and constants for the indexed min-heap timer.
// ----------------------------------------------------------------------------
`default_nettype none
package imht_pkg;
  localparam int unsigned HeapDepth = 256;
  localparam int unsigned IdSpace   = 1024;
  localparam int unsigned SlotW     = $clog2(HeapDepth);
  localparam int unsigned CntW      = $clog2(HeapDepth + 1);
  localparam int unsigned IdW       = 10;
  localparam int unsigned ExpW      = 32;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0, OP_POP = 3'd1, OP_PEEK = 3'd2, OP_MODIFY = 3'd3, OP_DELETE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_FULL = 3'd2, ST_DUP = 3'd3, ST_UNKNOWN = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_ROOT, S_POSRD, S_POSCHK, S_LASTRD, S_TAKE,
    S_UPRD, S_UPCMP, S_DNRD, S_DNCMP, S_PLACE, S_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]      op;
    logic [IdW-1:0]  client_id;
    logic [ExpW-1:0] expire_time;
  } req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [IdW-1:0]  out_client_id;
    logic [ExpW-1:0] out_expire_time;
  } rsp_t;
endpackage
`default_nettype wire

// ----- hdl/indexed_min_heap_timer_core.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_core
// Addressable binary min-heap of expiry times keyed by client id.
// ----------------------------------------------------------------------------
//  channel | dir | signals
//  req     | in  | req_valid_i req_ready_o req_i
//  rsp     | out | rsp_valid_o rsp_ready_i rsp_o
// One request at a time: a pop or peek of an empty heap and an unused op go
// from the lookup straight to the response. Sift-up reads the parent, then compares
// and moves, per level; sift-down reads the left child, reads the right child, then moves.
// After reset a pass over all 1024 id table entries clears them; ready stays low meanwhile.
// req_ready_o is low while a request is in work or a response waits.
`default_nettype none
`include "assert_macros.svh"
module indexed_min_heap_timer_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            req_valid_i,
  output logic                 req_ready_o,
  input  wire imht_pkg::req_t  req_i,
  output logic                 rsp_valid_o,
  input  wire logic            rsp_ready_i,
  output imht_pkg::rsp_t       rsp_o
);
  localparam int unsigned SW = imht_pkg::SlotW;
  localparam int unsigned CW = imht_pkg::CntW;
  localparam int unsigned IW = imht_pkg::IdW;
  localparam int unsigned EW = imht_pkg::ExpW;

  logic [EW-1:0] slot_exp_mem [imht_pkg::HeapDepth];
  logic [IW-1:0] slot_cli_mem [imht_pkg::HeapDepth];
  // id table entry: {present, slot}
  logic [SW:0]   cli_slot_mem [imht_pkg::IdSpace];

  imht_pkg::state_e state_q, state_d;
  imht_pkg::req_t req_q;
  imht_pkg::rsp_t rsp_q, rsp_d;
  logic rsp_valid_q, rsp_valid_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] clr_q, clr_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [IW-1:0] mid_q, mid_d;
  logic [EW-1:0] mexp_q, mexp_d;
  logic [EW-1:0] old_q, old_d;
  logic          right_q, right_d;
  logic [EW-1:0] lexp_q, lexp_d;
  logic [IW-1:0] lcli_q, lcli_d;

  // memory ports
  logic [SW-1:0] sa;
  logic          s_we;
  logic [EW-1:0] s_wexp;
  logic [IW-1:0] s_wcli;
  logic [EW-1:0] s_rexp;
  logic [IW-1:0] s_rcli;
  logic [IW-1:0] ca;
  logic          c_we;
  logic [SW:0]   c_wd;
  logic [SW:0]   c_rd;

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      slot_exp_mem[sa] <= s_wexp;
      slot_cli_mem[sa] <= s_wcli;
    end
    s_rexp <= slot_exp_mem[sa];
    s_rcli <= slot_cli_mem[sa];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      cli_slot_mem[ca] <= c_wd;
    end
    c_rd <= cli_slot_mem[ca];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imht_pkg::S_CLEAR;
      rsp_valid_q <= 1'b0;
      cnt_q       <= '0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) begin
      req_q <= req_i;
    end
    rsp_q   <= rsp_d;
    pos_q   <= pos_d;
    mid_q   <= mid_d;
    mexp_q  <= mexp_d;
    old_q   <= old_d;
    right_q <= right_d;
    lexp_q  <= lexp_d;
    lcli_q  <= lcli_d;
  end

  logic [CW-1:0] par, kid;
  logic [CW-1:0] cnt_m1;
  assign par    = (pos_q - CW'(1)) >> 1;
  assign kid    = {pos_q[CW-2:0], 1'b1};
  assign cnt_m1 = cnt_q - CW'(1);

  assign req_ready_o = (state_q == imht_pkg::S_IDLE) && !rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d = state_q;
    rsp_d = rsp_q;
    rsp_valid_d = rsp_valid_q;
    cnt_d = cnt_q;
    clr_d = clr_q;
    pos_d = pos_q;
    mid_d = mid_q;
    mexp_d = mexp_q;
    old_d = old_q;
    right_d = right_q;
    lexp_d = lexp_q;
    lcli_d = lcli_q;
    sa = pos_q[SW-1:0];
    s_we = 1'b0;
    s_wexp = mexp_q;
    s_wcli = mid_q;
    ca = req_q.client_id;
    c_we = 1'b0;
    c_wd = {1'b1, pos_q[SW-1:0]};
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    case (state_q)
      imht_pkg::S_CLEAR: begin
        ca = clr_q;
        c_we = 1'b1;
        c_wd = '0;
        clr_d = clr_q + IW'(1);
        if (clr_q == '1) begin
          state_d = imht_pkg::S_IDLE;
        end
      end
      imht_pkg::S_IDLE: begin
        if (req_valid_i && req_ready_o) begin
          state_d = imht_pkg::S_LOOKUP;
        end
      end
      imht_pkg::S_LOOKUP: begin
        rsp_d = '0;
        rsp_d.status = imht_pkg::ST_OK;
        state_d = imht_pkg::S_DONE;
        case (req_q.op)
          imht_pkg::OP_POP, imht_pkg::OP_PEEK: begin
            if (cnt_q == '0) begin
              rsp_d.status = imht_pkg::ST_EMPTY;
            end else begin
              sa = '0;
              pos_d = '0;
              state_d = imht_pkg::S_ROOT;
            end
          end
          imht_pkg::OP_PUSH, imht_pkg::OP_MODIFY, imht_pkg::OP_DELETE: begin
            state_d = imht_pkg::S_POSRD;
          end
          default: ;
        endcase
      end
      imht_pkg::S_ROOT: begin
        rsp_d.out_client_id = s_rcli;
        rsp_d.out_expire_time = s_rexp;
        old_d = s_rexp;
        if (req_q.op == imht_pkg::OP_POP) begin
          ca = s_rcli;
          c_we = 1'b1;
          c_wd = '0;
          state_d = imht_pkg::S_LASTRD;
        end else begin
          state_d = imht_pkg::S_DONE;
        end
      end
      imht_pkg::S_POSRD: begin
        pos_d = {1'b0, c_rd[SW-1:0]};
        sa = c_rd[SW-1:0];
        state_d = imht_pkg::S_DONE;
        if (req_q.op == imht_pkg::OP_PUSH) begin
          if (c_rd[SW]) begin
            rsp_d.status = imht_pkg::ST_DUP;
          end else if (cnt_q >= CW'(imht_pkg::HeapDepth)) begin
            rsp_d.status = imht_pkg::ST_FULL;
          end else begin
            pos_d = cnt_q;
            cnt_d = cnt_q + CW'(1);
            mid_d = req_q.client_id;
            mexp_d = req_q.expire_time;
            state_d = imht_pkg::S_UPRD;
          end
        end else if (!c_rd[SW]) begin
          rsp_d.status = imht_pkg::ST_UNKNOWN;
        end else begin
          state_d = imht_pkg::S_POSCHK;
        end
      end
      imht_pkg::S_POSCHK: begin
        old_d = s_rexp;
        if (pos_q >= cnt_q) begin
          rsp_d.status = imht_pkg::ST_UNKNOWN;
          state_d = imht_pkg::S_DONE;
        end else if (req_q.op == imht_pkg::OP_MODIFY) begin
          mid_d = req_q.client_id;
          mexp_d = req_q.expire_time;
          if (req_q.expire_time < s_rexp) begin
            state_d = imht_pkg::S_UPRD;
          end else if (req_q.expire_time > s_rexp) begin
            state_d = imht_pkg::S_DNRD;
          end else begin
            state_d = imht_pkg::S_DONE;
          end
        end else begin
          c_we = 1'b1;
          c_wd = '0;
          state_d = imht_pkg::S_LASTRD;
        end
      end
      imht_pkg::S_LASTRD: begin
        cnt_d = cnt_m1;
        sa = cnt_m1[SW-1:0];
        state_d = (pos_q == cnt_m1) ? imht_pkg::S_DONE : imht_pkg::S_TAKE;
      end
      imht_pkg::S_TAKE: begin
        mid_d = s_rcli;
        mexp_d = s_rexp;
        if (s_rexp < old_q) begin
          state_d = imht_pkg::S_UPRD;
        end else if (s_rexp > old_q) begin
          state_d = imht_pkg::S_DNRD;
        end else begin
          state_d = imht_pkg::S_PLACE;
        end
      end
      imht_pkg::S_UPRD: begin
        sa = par[SW-1:0];
        state_d = (pos_q == '0) ? imht_pkg::S_PLACE : imht_pkg::S_UPCMP;
      end
      imht_pkg::S_UPCMP: begin
        if (s_rexp <= mexp_q) begin
          state_d = imht_pkg::S_PLACE;
        end else begin
          s_we = 1'b1;
          s_wexp = s_rexp;
          s_wcli = s_rcli;
          ca = s_rcli;
          c_we = 1'b1;
          pos_d = par;
          state_d = imht_pkg::S_UPRD;
        end
      end
      imht_pkg::S_DNRD: begin
        right_d = 1'b0;
        if (kid >= cnt_q || pos_q[CW-1]) begin
          state_d = imht_pkg::S_PLACE;
        end else begin
          sa = kid[SW-1:0];
          state_d = imht_pkg::S_DNCMP;
        end
      end
      imht_pkg::S_DNCMP: begin
        if (!right_q) begin
          lexp_d = s_rexp;
          lcli_d = s_rcli;
          if (kid + CW'(1) < cnt_q) begin
            sa = kid[SW-1:0] + SW'(1);
            right_d = 1'b1;
          end else if (s_rexp >= mexp_q) begin
            state_d = imht_pkg::S_PLACE;
          end else begin
            s_we = 1'b1;
            s_wexp = s_rexp;
            s_wcli = s_rcli;
            ca = s_rcli;
            c_we = 1'b1;
            pos_d = kid;
            state_d = imht_pkg::S_DNRD;
          end
        end else begin
          s_wexp = (s_rexp < lexp_q) ? s_rexp : lexp_q;
          s_wcli = (s_rexp < lexp_q) ? s_rcli : lcli_q;
          if (s_wexp >= mexp_q) begin
            state_d = imht_pkg::S_PLACE;
          end else begin
            s_we = 1'b1;
            ca = s_wcli;
            c_we = 1'b1;
            pos_d = (s_rexp < lexp_q) ? kid + CW'(1) : kid;
            state_d = imht_pkg::S_DNRD;
          end
        end
      end
      imht_pkg::S_PLACE: begin
        s_we = 1'b1;
        ca = mid_q;
        c_we = 1'b1;
        state_d = imht_pkg::S_DONE;
      end
      imht_pkg::S_DONE: begin
        rsp_valid_d = 1'b1;
        state_d = imht_pkg::S_IDLE;
      end
      default: state_d = imht_pkg::S_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(imht_pkg::HeapDepth))
  `ASSERT_NEVER(a_ready_busy, clk_i, rst_ni, req_ready_o && rsp_valid_o)
  `ASSERT_IMPL(a_done_rsp, clk_i, rst_ni, (state_q == imht_pkg::S_DONE) |=> rsp_valid_q)
endmodule
`default_nettype wire

// ----- bench/indexed_min_heap_timer_core_tb.sv -----
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_core_tb
// Drives push, pop, peek, modify and delete requests into the heap timer with
// random gaps and response stalls. A behavioral indexed heap predicts each
// response, and the monitor compares every response beat with the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none
module indexed_min_heap_timer_core_tb;
  localparam int Depth = imht_pkg::HeapDepth;
  localparam int Ids   = imht_pkg::IdSpace;
  localparam int WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  imht_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  imht_pkg::rsp_t rsp_o;

  indexed_min_heap_timer_core u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid_i), .req_ready_o(req_ready_o), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_ready_i(rsp_ready_i), .rsp_o(rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // heap model
  logic [31:0] hp_exp [Depth];
  logic [9:0]  hp_id  [Depth];
  int          id_pos [Ids];
  bit          id_in  [Ids];
  int          hp_cnt;

  imht_pkg::req_t pending_reqs[$];
  imht_pkg::rsp_t expected_rsps[$];
  int   mismatches;
  bit   stim_done;
  int   req_wait, rsp_wait, idle_cycles;

  function automatic void heap_place(int s, logic [9:0] id, logic [31:0] e);
    hp_exp[s] = e;
    hp_id[s]  = id;
    id_pos[id] = s;
  endfunction

  function automatic void heap_rise(int p);
    logic [9:0] id;
    logic [31:0] e;
    int par;
    if (p >= hp_cnt) return;
    id = hp_id[p];
    e  = hp_exp[p];
    while (p > 0) begin
      par = (p - 1) / 2;
      if (hp_exp[par] <= e) break;
      heap_place(p, hp_id[par], hp_exp[par]);
      p = par;
    end
    heap_place(p, id, e);
  endfunction

  function automatic void heap_sink(int p);
    logic [9:0] id;
    logic [31:0] e;
    int k;
    if (p >= hp_cnt) return;
    id = hp_id[p];
    e  = hp_exp[p];
    forever begin
      k = 2 * p + 1;
      if (k >= hp_cnt) break;
      if (k + 1 < hp_cnt && hp_exp[k+1] < hp_exp[k]) k++;
      if (hp_exp[k] >= e) break;
      heap_place(p, hp_id[k], hp_exp[k]);
      p = k;
    end
    heap_place(p, id, e);
  endfunction

  function automatic void heap_remove(int p);
    logic [31:0] old;
    old = hp_exp[p];
    id_in[hp_id[p]] = 1'b0;
    hp_cnt--;
    if (p == hp_cnt) return;
    heap_place(p, hp_id[hp_cnt], hp_exp[hp_cnt]);
    if (hp_exp[p] < old) heap_rise(p);
    else if (hp_exp[p] > old) heap_sink(p);
  endfunction

  function automatic imht_pkg::rsp_t heap_apply(imht_pkg::req_t r);
    imht_pkg::rsp_t o;
    logic [31:0] old;
    int p;
    o = '0;
    o.status = imht_pkg::ST_OK;
    case (r.op)
      imht_pkg::OP_POP, imht_pkg::OP_PEEK: begin
        if (hp_cnt == 0) o.status = imht_pkg::ST_EMPTY;
        else begin
          o.out_client_id = hp_id[0];
          o.out_expire_time = hp_exp[0];
          if (r.op == imht_pkg::OP_POP) heap_remove(0);
        end
      end
      imht_pkg::OP_PUSH: begin
        if (id_in[r.client_id]) o.status = imht_pkg::ST_DUP;
        else if (hp_cnt >= Depth) o.status = imht_pkg::ST_FULL;
        else begin
          id_in[r.client_id] = 1'b1;
          heap_place(hp_cnt, r.client_id, r.expire_time);
          hp_cnt++;
          heap_rise(hp_cnt - 1);
        end
      end
      imht_pkg::OP_MODIFY, imht_pkg::OP_DELETE: begin
        if (!id_in[r.client_id]) o.status = imht_pkg::ST_UNKNOWN;
        else begin
          p = id_pos[r.client_id];
          if (r.op == imht_pkg::OP_MODIFY) begin
            old = hp_exp[p];
            hp_exp[p] = r.expire_time;
            if (r.expire_time < old) heap_rise(p);
            else if (r.expire_time > old) heap_sink(p);
          end else heap_remove(p);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic imht_pkg::req_t mk_req(logic [2:0] op, logic [9:0] id, logic [31:0] e);
    imht_pkg::req_t r;
    r.op = op;
    r.client_id = id;
    r.expire_time = e;
    return r;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && req_ready_o) begin
        expected_rsps.push_back(heap_apply(req_i));
        req_wait <= $urandom_range(0, 14);
        if (req_wait == 0 && pending_reqs.size() != 0 && $urandom_range(0, 1)) begin
          req_i <= pending_reqs.pop_front();
        end else req_valid_i <= 1'b0;
      end else if (!req_valid_i) begin
        if (req_wait > 0) req_wait <= req_wait - 1;
        else if (pending_reqs.size() != 0) begin
          req_i <= pending_reqs.pop_front();
          req_valid_i <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    imht_pkg::rsp_t want;
    if (rst_ni) begin
      if (rsp_valid_o && rsp_ready_i) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response beat %p", rsp_o);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d id=%0d t=%0h got st=%0d id=%0d t=%0h",
                       want.status, want.out_client_id, want.out_expire_time,
                       rsp_o.status, rsp_o.out_client_id, rsp_o.out_expire_time);
          end
        end
        rsp_wait = $urandom_range(0, 14);
        rsp_ready_i <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
        rsp_wait--;
        rsp_ready_i <= (rsp_wait == 0);
      end else rsp_ready_i <= 1'b1;
      if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] rnd_exp(int mode);
    case (mode)
      0: return 32'hFFFF_FFFF;
      1: return 32'h0;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [9:0] rnd_id(int narrow);
    if (narrow) return 10'($urandom_range(0, 299));
    return 10'($urandom);
  endfunction

  initial begin
    int n, k, fillmode;
    logic [2:0] op;
    hp_cnt = 0;
    mismatches = 0;
    stim_done = 0;
    req_wait = 0;
    rsp_wait = 0;
    idle_cycles = 0;
    for (int i = 0; i < Ids; i++) id_in[i] = 1'b0;

    // directed
    pending_reqs.push_back(mk_req(imht_pkg::OP_POP, 0, 0));
    pending_reqs.push_back(mk_req(imht_pkg::OP_PEEK, 0, 0));
    pending_reqs.push_back(mk_req(imht_pkg::OP_MODIFY, 1023, 5));
    pending_reqs.push_back(mk_req(imht_pkg::OP_DELETE, 0, 0));
    pending_reqs.push_back(mk_req(imht_pkg::OP_PUSH, 1023, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_req(imht_pkg::OP_PUSH, 1023, 1));
    pending_reqs.push_back(mk_req(imht_pkg::OP_PUSH, 0, 0));
    pending_reqs.push_back(mk_req(imht_pkg::OP_PUSH, 5, 100));
    pending_reqs.push_back(mk_req(imht_pkg::OP_PUSH, 6, 100));
    pending_reqs.push_back(mk_req(imht_pkg::OP_MODIFY, 5, 100));
    pending_reqs.push_back(mk_req(imht_pkg::OP_MODIFY, 1023, 0));
    pending_reqs.push_back(mk_req(imht_pkg::OP_MODIFY, 0, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_req(imht_pkg::OP_PEEK, 0, 0));
    pending_reqs.push_back(mk_req(imht_pkg::OP_DELETE, 6, 0));
    pending_reqs.push_back(mk_req(3'd5, 7, 9));
    pending_reqs.push_back(mk_req(3'd6, 0, 0));
    pending_reqs.push_back(mk_req(3'd7, 1023, 32'hFFFF_FFFF));
    pending_reqs.push_back(mk_req(imht_pkg::OP_POP, 0, 0));
    pending_reqs.push_back(mk_req(imht_pkg::OP_POP, 0, 0));
    pending_reqs.push_back(mk_req(imht_pkg::OP_POP, 0, 0));
    pending_reqs.push_back(mk_req(imht_pkg::OP_POP, 0, 0));
    pending_reqs.push_back(mk_req(imht_pkg::OP_PEEK, 0, 0));

    // fill to full, then duplicate and full refusals, then modifies and deletes, then drain
    for (int i = 0; i < Depth; i++)
      pending_reqs.push_back(mk_req(imht_pkg::OP_PUSH, 10'(i * 3), $urandom));
    pending_reqs.push_back(mk_req(imht_pkg::OP_PUSH, 3, 1));
    pending_reqs.push_back(mk_req(imht_pkg::OP_PUSH, 1000, 1));
    for (int i = 0; i < 60; i++)
      pending_reqs.push_back(mk_req(imht_pkg::OP_MODIFY, 10'($urandom_range(0, 255) * 3),
                                    rnd_exp($urandom_range(0, 3))));
    for (int i = 0; i < 40; i++)
      pending_reqs.push_back(mk_req(imht_pkg::OP_DELETE, 10'($urandom_range(0, 255) * 3), 0));
    for (int i = 0; i < Depth; i++) pending_reqs.push_back(mk_req(imht_pkg::OP_POP, 0, 0));

    // random phases, biased toward ids in a small window so hits are common
    n = 1000;
    while (n > 0) begin
      fillmode = $urandom_range(0, 3);
      k = $urandom_range(20, 120);
      for (int i = 0; i < k && n > 0; i++, n--) begin
        case ($urandom_range(0, 9))
          0, 1, 2: op = (fillmode == 3) ? imht_pkg::OP_POP : imht_pkg::OP_PUSH;
          3:       op = imht_pkg::OP_POP;
          4:       op = imht_pkg::OP_PEEK;
          5, 6:    op = imht_pkg::OP_MODIFY;
          7, 8:    op = imht_pkg::OP_DELETE;
          default: op = 3'($urandom);
        endcase
        pending_reqs.push_back(mk_req(op, rnd_id($urandom_range(0, 7) != 0),
                                      rnd_exp($urandom_range(0, 5))));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    wait (pending_reqs.size() == 0 && !req_valid_i && expected_rsps.size() == 0
          || idle_cycles >= WatchLimit);
    if (idle_cycles < WatchLimit) begin
      repeat (40) @(posedge clk_i);
      if (mismatches == 0 && expected_rsps.size() == 0 && !rsp_valid_o)
        $display("end of test: clean");
      else
        $display("end of test: mismatches");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+hdl
hdl/imht_pkg.sv
hdl/indexed_min_heap_timer_core.sv
bench/indexed_min_heap_timer_core_tb.sv
